// File: rtl/brf_pkg.sv
// Package with the constants, word types and control structs of the byte ring FIFO.
`timescale 1ns / 1ps

package brf_pkg;

  localparam int STORE_DEPTH  = 1024;
  localparam int MAX_BURST    = 64;

  // Largest usable capacity is the largest power of two that fits in the store.
  localparam int CAP_MAX_LOG2 = $clog2(STORE_DEPTH + 1) - 1;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int PTR_W        = CAP_MAX_LOG2 + 1;
  localparam int BURST_W      = $clog2(MAX_BURST + 1);

  localparam int CFG_W        = 4;
  localparam int BYTE_W       = 8;
  localparam int LIMIT_W      = 7;
  localparam int COUNT_W      = 11;
  localparam int DROP_W       = 32;

  localparam logic [CFG_W-1:0] CAP_RESET = 4'd10;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic               op;
    logic [BYTE_W-1:0]  write_byte;
    logic               write_last;
    logic [LIMIT_W-1:0] read_limit;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  read_byte;
    logic               read_valid;
    logic               burst_last;
    logic               write_accepted;
    logic [COUNT_W-1:0] used_count;
    logic [COUNT_W-1:0] free_count;
    logic [DROP_W-1:0]  dropped_total;
    logic [COUNT_W-1:0] peak_used;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD_DATA
  } state_t;

  typedef struct packed {
    logic item_load;
    logic exec_write;
    logic exec_empty;
    logic read_start;
    logic read_emit;
    logic read_issue;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic take_zero;
    logic remain_zero;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/brf_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/brf_ctrl.sv
// Controller state machine that sequences writes, empty reads and read bursts.
`timescale 1ns / 1ps

module brf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  brf_pkg::dp_status_t status,
  output brf_pkg::ctrl_cmd_t  cmd
);

  brf_pkg::state_t state;
  brf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      brf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_next    = brf_pkg::ST_EXEC;
        end
      end
      brf_pkg::ST_EXEC: begin
        if (!status.is_read) begin
          if (status.out_free) begin
            cmd.exec_write = 1'b1;
            state_next     = brf_pkg::ST_IDLE;
          end
        end else if (status.take_zero) begin
          if (status.out_free) begin
            cmd.exec_empty = 1'b1;
            state_next     = brf_pkg::ST_IDLE;
          end
        end else begin
          // First byte is fetched here; the RAM returns it next cycle.
          cmd.read_start = 1'b1;
          state_next     = brf_pkg::ST_RD_DATA;
        end
      end
      brf_pkg::ST_RD_DATA: begin
        if (status.out_free) begin
          cmd.read_emit = 1'b1;
          if (status.remain_zero) begin
            state_next = brf_pkg::ST_IDLE;
          end else begin
            cmd.read_issue = 1'b1;
          end
        end
      end
      default: begin
        state_next = brf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/brf_dp.sv
// Datapath with pointers, statistics, the byte store and the output register.
`timescale 1ns / 1ps

module brf_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [brf_pkg::CFG_W-1:0]    cfg_wr_data,
  input  brf_pkg::in_word_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output brf_pkg::out_word_t           out_data,
  input  brf_pkg::ctrl_cmd_t           cmd,
  output brf_pkg::dp_status_t          status
);

  localparam int PW = brf_pkg::PTR_W;
  localparam int AW = brf_pkg::ADDR_W;
  localparam int BW = brf_pkg::BURST_W;

  brf_pkg::in_word_t             item;
  logic [brf_pkg::CFG_W-1:0]     cap_log2;
  logic [PW-1:0]                 wp;
  logic [PW-1:0]                 rp;
  logic [brf_pkg::DROP_W-1:0]    drops;
  logic [PW-1:0]                 peak;
  logic [BW-1:0]                 remaining;
  logic [PW-1:0]                 fin_used;

  logic [PW-1:0]                 cap;
  logic [PW:0]                   pmask_wide;
  logic [PW-1:0]                 pmask;
  logic [PW-1:0]                 amask;
  logic [PW-1:0]                 used;
  logic                          room;
  logic [PW-1:0]                 wp_inc;
  logic [PW-1:0]                 rp_inc;
  logic [PW-1:0]                 used_new;
  logic [brf_pkg::DROP_W-1:0]    drops_next;
  logic [PW-1:0]                 peak_next;
  logic [BW-1:0]                 lim;
  logic [BW-1:0]                 take;
  logic [PW-1:0]                 used_sel;
  logic                          out_load;
  logic                          ram_we;
  logic                          ram_re;
  logic [brf_pkg::BYTE_W-1:0]    ram_rdata;
  brf_pkg::out_word_t            out_data_next;

  always_comb begin
    if (int'(cap_log2) > brf_pkg::CAP_MAX_LOG2) begin
      cap = PW'(1) << brf_pkg::CAP_MAX_LOG2;
    end else begin
      cap = PW'(1) << cap_log2;
    end
    // Pointers run modulo twice the capacity so full and empty differ.
    pmask_wide = {cap, 1'b0} - (PW + 1)'(1);
    pmask      = pmask_wide[PW-1:0];
    amask      = cap - PW'(1);
    used       = (wp - rp) & pmask;
    room       = (used < cap);
    wp_inc     = (wp + PW'(1)) & pmask;
    rp_inc     = (rp + PW'(1)) & pmask;
    used_new   = used + PW'(room);
    drops_next = drops + brf_pkg::DROP_W'(!room);
    if (item.write_last && (used_new > peak)) begin
      peak_next = used_new;
    end else begin
      peak_next = peak;
    end
    if (int'(item.read_limit) > brf_pkg::MAX_BURST) begin
      lim = BW'(brf_pkg::MAX_BURST);
    end else begin
      lim = BW'(item.read_limit);
    end
    if (int'(used) < int'(lim)) begin
      take = BW'(used);
    end else begin
      take = lim;
    end
  end

  assign out_load = cmd.exec_write | cmd.exec_empty | cmd.read_emit;
  assign ram_we   = cmd.exec_write & room;
  assign ram_re   = cmd.read_start | cmd.read_issue;

  assign status.is_read     = (item.op == brf_pkg::OP_READ);
  assign status.take_zero   = (take == '0);
  assign status.remain_zero = (remaining == '0);
  assign status.out_free    = !out_valid || out_ready;

  brf_ram #(
    .WIDTH (brf_pkg::BYTE_W),
    .DEPTH (brf_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(wp & amask)),
    .wdata (item.write_byte),
    .re    (ram_re),
    .raddr (AW'(rp & amask)),
    .rdata (ram_rdata)
  );

  always_comb begin
    out_data_next                = '0;
    out_data_next.burst_last     = 1'b1;
    out_data_next.dropped_total  = drops;
    out_data_next.peak_used      = brf_pkg::COUNT_W'(peak);
    used_sel                     = used;
    if (cmd.exec_write) begin
      used_sel                       = used_new;
      out_data_next.write_accepted   = room;
      out_data_next.dropped_total    = drops_next;
      out_data_next.peak_used        = brf_pkg::COUNT_W'(peak_next);
    end else if (cmd.read_emit) begin
      // Burst results report the fill level as it stands after the whole burst.
      used_sel                   = fin_used;
      out_data_next.read_byte    = ram_rdata;
      out_data_next.read_valid   = 1'b1;
      out_data_next.burst_last   = status.remain_zero;
    end
    out_data_next.used_count = brf_pkg::COUNT_W'(used_sel);
    out_data_next.free_count = brf_pkg::COUNT_W'(cap - used_sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_log2  <= brf_pkg::CAP_RESET;
      wp        <= '0;
      rp        <= '0;
      drops     <= '0;
      peak      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_log2 <= cfg_wr_data;
        wp       <= '0;
        rp       <= '0;
        drops    <= '0;
        peak     <= '0;
      end else begin
        if (cmd.exec_write) begin
          if (room) begin
            wp <= wp_inc;
          end
          drops <= drops_next;
          peak  <= peak_next;
        end
        if (ram_re) begin
          rp <= rp_inc;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item <= in_data;
    end
    if (cmd.read_start) begin
      remaining <= take - BW'(1);
      fin_used  <= used - PW'(take);
    end else if (cmd.read_issue) begin
      remaining <= remaining - BW'(1);
    end
    if (out_load) begin
      out_data <= out_data_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) used <= cap)
    else $error("fill level exceeds capacity");

  assert property (@(posedge clk) disable iff (rst) cmd.read_start |-> used != '0)
    else $error("read burst started on an empty ring");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.read_valid && out_data.write_accepted))
    else $error("result marks both a read byte and a stored write");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.exec_write && !room && !cfg_wr_en) |=> drops == $past(drops) + 1)
    else $error("dropped word not counted");

endmodule

// File: rtl/byte_ring_fifo_with_drop_stats_top.sv
// Top level of the byte ring FIFO with drop and peak statistics.
// A write word gives its result from the execute state; the next word is taken only back in idle.
// A read burst reads its first byte from the store in the execute state, then emits one byte per cycle,
// paced by the registered read port of the byte store and by out_ready.
// An empty read gives its single result from the execute state.
// Synchronous reset sets capacity 1024 and clears pointers and statistics; store is not cleared.
`timescale 1ns / 1ps

module byte_ring_fifo_with_drop_stats_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [brf_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  brf_pkg::in_word_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output brf_pkg::out_word_t        out_data
);

  brf_pkg::ctrl_cmd_t  cmd;
  brf_pkg::dp_status_t status;

  brf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  brf_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the byte ring FIFO with drop and peak statistics.
`timescale 1ns / 1ps

module testbench;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_WORDS = 20;

  typedef struct {
    brf_pkg::in_word_t w;
    bit                hold;
  } tx_item_t;

  logic      clk;
  logic      rst = 1'b1;
  logic      cfg_wr_en = 1'b0;
  logic [brf_pkg::CFG_W-1:0] cfg_wr_data = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  brf_pkg::in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  brf_pkg::out_word_t out_data;

  byte_ring_fifo_with_drop_stats_top uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // Shadow copy of the ring, pointers and statistics.
  logic [brf_pkg::BYTE_W-1:0] ring_mem [brf_pkg::STORE_DEPTH];
  int unsigned cap = brf_pkg::STORE_DEPTH;
  int unsigned wr_ptr = 0;
  int unsigned rd_ptr = 0;
  logic [brf_pkg::DROP_W-1:0] drop_cnt = '0;
  int unsigned peak = 0;

  tx_item_t  tx_words[$];
  brf_pkg::out_word_t due_words[$];

  int send_idle = 0;
  int recv_idle = 0;
  int quiet = 0;
  int mismatches = 0;
  int words_in = 0;
  int words_out = 0;
  int bytes_read = 0;
  int writes_dropped = 0;
  int cap_settings = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic brf_pkg::out_word_t with_stats(input brf_pkg::out_word_t r,
                                                   input int unsigned used);
    brf_pkg::out_word_t o;
    o = r;
    o.used_count = used[brf_pkg::COUNT_W-1:0];
    o.free_count = brf_pkg::COUNT_W'(cap - used);
    o.dropped_total = drop_cnt;
    o.peak_used = peak[brf_pkg::COUNT_W-1:0];
    return o;
  endfunction

  // Applies one accepted word to the shadow ring and queues the results it causes.
  task automatic ring_apply(input brf_pkg::in_word_t w);
    int unsigned mask, used, lim, take, start;
    brf_pkg::out_word_t r;
    mask = 2 * cap - 1;
    used = (wr_ptr - rd_ptr) & mask;
    r = '0;
    if (w.op == brf_pkg::OP_WRITE) begin
      if (used < cap) begin
        ring_mem[brf_pkg::ADDR_W'(wr_ptr & (cap - 1))] = w.write_byte;
        wr_ptr = (wr_ptr + 1) & mask;
        r.write_accepted = 1'b1;
      end else begin
        drop_cnt = drop_cnt + 1;
        writes_dropped++;
      end
      used = (wr_ptr - rd_ptr) & mask;
      // The peak follows the end of a burst even when that last byte was dropped.
      if (w.write_last && used > peak) begin
        peak = used;
      end
      r.burst_last = 1'b1;
      due_words.push_back(with_stats(r, used));
    end else begin
      lim = (w.read_limit > brf_pkg::MAX_BURST) ? brf_pkg::MAX_BURST : w.read_limit;
      take = (used < lim) ? used : lim;
      if (take == 0) begin
        r.burst_last = 1'b1;
        due_words.push_back(with_stats(r, used));
      end else begin
        start = rd_ptr;
        rd_ptr = (rd_ptr + take) & mask;
        used = used - take;
        // All bytes of a burst report the counts as they stand after the whole burst.
        for (int i = 0; i < take; i++) begin
          r.read_byte = ring_mem[brf_pkg::ADDR_W'((start + i) & (cap - 1))];
          r.read_valid = 1'b1;
          r.burst_last = (i == take - 1);
          due_words.push_back(with_stats(r, used));
        end
      end
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic push_word(input logic op, input logic [brf_pkg::BYTE_W-1:0] b,
                           input logic last, input logic [brf_pkg::LIMIT_W-1:0] lim,
                           input bit hold = 1'b0);
    tx_item_t t;
    t.w.op = op;
    t.w.write_byte = b;
    t.w.write_last = last;
    t.w.read_limit = lim;
    t.hold = hold | ($urandom_range(39) == 0);
    tx_words.push_back(t);
  endtask

  task automatic wait_drained();
    while (!(tx_words.size() == 0 && !in_valid && due_words.size() == 0)) begin
      @(posedge clk);
    end
  endtask

  task automatic write_capacity(input logic [brf_pkg::CFG_W-1:0] v);
    wait_drained();
    repeat (6) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    cap = 1 << v;
    while (cap > brf_pkg::STORE_DEPTH) begin
      cap = cap >> 1;
    end
    wr_ptr = 0;
    rd_ptr = 0;
    drop_cnt = '0;
    peak = 0;
    cap_settings++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly write bursts followed by a read, with some loose words mixed in.
  task automatic queue_traffic(input int unsigned count);
    int unsigned n, len, len_max, pick;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        len_max = (2 * cap + 1 < 40) ? 2 * cap + 1 : 40;
        len = $urandom_range(len_max, 1);
        for (int i = 0; i < len; i++) begin
          push_word(brf_pkg::OP_WRITE, brf_pkg::BYTE_W'($urandom), (i == len - 1),
                    brf_pkg::LIMIT_W'($urandom_range(127)));
        end
        n += len;
        if ($urandom_range(99) < 70) begin
          pick = $urandom_range(9);
          push_word(brf_pkg::OP_READ, brf_pkg::BYTE_W'($urandom), 1'($urandom_range(1)),
                    brf_pkg::LIMIT_W'((pick == 0) ? 0 :
                                      (pick == 1) ? $urandom_range(127, 65)
                                                  : $urandom_range(64, 1)));
          n++;
        end
      end else begin
        push_word(1'($urandom_range(1)), brf_pkg::BYTE_W'($urandom), 1'($urandom_range(1)),
                  brf_pkg::LIMIT_W'($urandom_range(127)));
        n++;
      end
    end
  endtask

  // Driver: a word stays on the bus until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        ring_apply(in_data);
        words_in++;
      end
      if (!in_valid || in_ready) begin
        if (tx_words.size() != 0 &&
            !(tx_words[0].hold && (due_words.size() != 0 || (out_valid && out_ready))) &&
            $urandom_range(99) >= send_idle) begin
          in_data <= tx_words[0].w;
          in_valid <= 1'b1;
          tx_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Monitor: each result word is checked against the oldest one due.
  always @(posedge clk) begin : result_check
    brf_pkg::out_word_t want;
    if (!rst && out_valid && out_ready) begin
      words_out++;
      if (due_words.size() == 0) begin
        flag_mismatch("result word with none due", 32'(out_data.used_count), 32'(0));
      end else begin
        want = due_words.pop_front();
        if (want.read_valid) begin
          bytes_read++;
        end
        if (out_data.read_byte !== want.read_byte)
          flag_mismatch("read_byte", 32'(out_data.read_byte), 32'(want.read_byte));
        if (out_data.read_valid !== want.read_valid)
          flag_mismatch("read_valid", 32'(out_data.read_valid), 32'(want.read_valid));
        if (out_data.burst_last !== want.burst_last)
          flag_mismatch("burst_last", 32'(out_data.burst_last), 32'(want.burst_last));
        if (out_data.write_accepted !== want.write_accepted)
          flag_mismatch("write_accepted", 32'(out_data.write_accepted),
                        32'(want.write_accepted));
        if (out_data.used_count !== want.used_count)
          flag_mismatch("used_count", 32'(out_data.used_count), 32'(want.used_count));
        if (out_data.free_count !== want.free_count)
          flag_mismatch("free_count", 32'(out_data.free_count), 32'(want.free_count));
        if (out_data.dropped_total !== want.dropped_total)
          flag_mismatch("dropped_total", out_data.dropped_total, want.dropped_total);
        if (out_data.peak_used !== want.peak_used)
          flag_mismatch("peak_used", 32'(out_data.peak_used), 32'(want.peak_used));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    wait (quiet >= QUIET_LIMIT);
    $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic [brf_pkg::CFG_W-1:0] caps [9];
    caps = '{4'd3, 4'd0, 4'd5, 4'd15, 4'd1, 4'd4, 4'd2, 4'd11, 4'd6};
    send_idle <= 23;
    recv_idle <= 51;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset capacity: empty reads, byte extremes, a zero limit and an oversized one.
    push_word(brf_pkg::OP_READ, 8'hff, 1'b1, 7'd5);
    push_word(brf_pkg::OP_WRITE, 8'h00, 1'b0, 7'd0);
    push_word(brf_pkg::OP_WRITE, 8'hff, 1'b1, 7'd127);
    push_word(brf_pkg::OP_READ, 8'h00, 1'b0, 7'd0);
    push_word(brf_pkg::OP_READ, 8'hff, 1'b1, 7'd127, 1'b1);
    push_word(brf_pkg::OP_READ, 8'h00, 1'b0, 7'd64);

    // Single-byte ring: the last byte of a burst is dropped and still sets the peak.
    write_capacity(4'd0);
    push_word(brf_pkg::OP_WRITE, 8'ha5, 1'b0, 7'd0);
    push_word(brf_pkg::OP_WRITE, 8'h5a, 1'b1, 7'd0);
    push_word(brf_pkg::OP_READ, 8'h00, 1'b0, 7'd64);
    push_word(brf_pkg::OP_WRITE, 8'h3c, 1'b1, 7'd0);
    push_word(brf_pkg::OP_READ, 8'h00, 1'b0, 7'd1);

    write_capacity(4'd2);
    push_word(brf_pkg::OP_WRITE, 8'h11, 1'b0, 7'd0);
    push_word(brf_pkg::OP_WRITE, 8'h22, 1'b0, 7'd0);
    push_word(brf_pkg::OP_WRITE, 8'h33, 1'b0, 7'd0);
    push_word(brf_pkg::OP_WRITE, 8'h44, 1'b0, 7'd0);
    push_word(brf_pkg::OP_WRITE, 8'h55, 1'b1, 7'd0);
    push_word(brf_pkg::OP_READ, 8'h00, 1'b0, 7'd3);
    push_word(brf_pkg::OP_WRITE, 8'h66, 1'b1, 7'd0);
    push_word(brf_pkg::OP_READ, 8'h00, 1'b0, 7'd127);
    push_word(brf_pkg::OP_READ, 8'h00, 1'b0, 7'd1);

    // A setting past the store size is clamped to the full store.
    write_capacity(4'd15);
    push_word(brf_pkg::OP_WRITE, 8'h7e, 1'b1, 7'd0);
    push_word(brf_pkg::OP_WRITE, 8'h81, 1'b0, 7'd127);
    push_word(brf_pkg::OP_READ, 8'h00, 1'b0, 7'd64);

    for (int p = 0; p < 9; p++) begin
      write_capacity(caps[p]);
      if (p == 3) begin
        send_idle <= 51;
        recv_idle <= 23;
      end else if (p == 6) begin
        send_idle <= 0;
        recv_idle <= 0;
      end
      @(posedge clk);
      queue_traffic(PHASE_WORDS);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (due_words.size() != 0) begin
      flag_mismatch("result words never delivered", 32'(due_words.size()), 32'(0));
    end
    $display("covered %0d input words and %0d result words over %0d capacity settings",
             words_in, words_out, cap_settings + 1);
    $display("%0d bytes read back, %0d writes dropped on a full ring",
             bytes_read, writes_dropped);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
